FILE: hw/rtl/packbits_plane_unpacker_core_macros.svh
// Assertion macros used by the plane unpacker top level.
`ifndef PACKBITS_PLANE_UNPACKER_CORE_MACROS_SVH
`define PACKBITS_PLANE_UNPACKER_CORE_MACROS_SVH
`ifndef SYNTH
`define PPU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plane unpacker check failed");
`define PPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plane unpacker check failed");
`else
`define PPU_ASSERT_NOW(label, ante, cons)
`define PPU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/ppu_pkg.sv
// Shared types and constants of the plane unpacker.
package ppu_pkg;

  localparam int BYTE_W       = 8;
  localparam int ADDR_W       = 19;
  localparam int DATA_W       = 32;
  localparam int LANE_W       = 4;
  localparam int RUN_W        = 8;
  localparam int CFG_DATA_W   = 11;
  localparam int PLANES_REG_W = 3;
  localparam int ROWS_REG_W   = 9;
  localparam int LINES_REG_W  = 11;

  localparam int MAX_PLANES_DEFAULT    = 4;
  localparam int MAX_ROW_BYTES_DEFAULT = 256;
  localparam int MAX_LINES_DEFAULT     = 1024;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] CTRL_REPEAT = 8'h80;
  localparam logic [BYTE_W:0]   REPEAT_BASE = 9'd257;

  typedef enum logic [1:0] {
    REG_MODE      = 2'd0,
    REG_PLANES    = 2'd1,
    REG_ROW_BYTES = 2'd2,
    REG_LINES     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              first_byte;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] out_word_addr;
    logic [DATA_W-1:0] out_data;
    logic [LANE_W-1:0] out_lanes;
    logic              picture_done;
    logic              overrun;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    logic                    compressed_mode;
    logic [PLANES_REG_W-1:0] plane_count;
    logic [ROWS_REG_W-1:0]   row_bytes;
    logic [LINES_REG_W-1:0]  line_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    compressed_mode: 1'b1,
    plane_count:     3'd4,
    row_bytes:       9'd40,
    line_count:      11'd200
  };

  // One classified input byte: how many row bytes it writes and whether the row may end.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first;
    logic [RUN_W-1:0]  count;
    logic              row_check;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: hw/rtl/packbits_plane_unpacker_core.sv
// Top level of the plane unpacker: register file, front end, op queue and back end.
// With the back end idle, a byte passes the op queue, then the S_BASE and S_RUN states, before
// its first result beat is registered. A literal, copied or control byte goes through the row
// base multiply, then the write; a repeat run writes one four-byte group per write step. The front
// takes a byte a cycle while the two-entry queue has room. Reset clears packet state, picture
// position and the output valid flag, and loads the register defaults.
`include "packbits_plane_unpacker_core_macros.svh"
module packbits_plane_unpacker_core #(
  parameter int MAX_PLANES    = ppu_pkg::MAX_PLANES_DEFAULT,
  parameter int MAX_ROW_BYTES = ppu_pkg::MAX_ROW_BYTES_DEFAULT,
  parameter int MAX_LINES     = ppu_pkg::MAX_LINES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ppu_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ppu_pkg::out_item_t                 out_item,
  input  logic                               cfg_we,
  input  ppu_pkg::reg_idx_t                  cfg_addr,
  input  logic [ppu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ppu_pkg::*;

  cfg_t   cfg;
  logic   push, pop;
  op_t    push_op, pop_op;
  qstat_t q_stat;
  logic   beat_flagged, beat_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:      cfg.compressed_mode <= cfg_wdata[0];
        REG_PLANES:    cfg.plane_count     <= cfg_wdata[PLANES_REG_W-1:0];
        REG_ROW_BYTES: cfg.row_bytes       <= cfg_wdata[ROWS_REG_W-1:0];
        REG_LINES:     cfg.line_count      <= cfg_wdata[LINES_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ppu_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .compressed_mode (cfg.compressed_mode),
    .q_stat          (q_stat),
    .push            (push),
    .push_op         (push_op)
  );

  ppu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .q_stat  (q_stat)
  );

  ppu_back #(
    .MAX_PLANES    (MAX_PLANES),
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .MAX_LINES     (MAX_LINES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .pop_op    (pop_op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign beat_flagged = out_item.picture_done || out_item.overrun;
  assign beat_empty   = out_valid && (out_item.out_lanes == '0);

  // Status flags only ever ride on the closing beat of a byte.
  `PPU_ASSERT_NOW(a_flags_on_last, out_valid && beat_flagged, out_item.last_of_run)
  // A beat with no bytes exists only to carry a flag.
  `PPU_ASSERT_NOW(a_empty_beat_flagged, beat_empty, out_item.last_of_run && beat_flagged)
  `PPU_ASSERT_NEXT(a_push_fills_queue, push, !q_stat.empty)

endmodule

FILE: hw/rtl/ppu_front.sv
// Front end: takes input beats and tracks packet state to classify each byte.
module ppu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppu_pkg::in_item_t in_item,
  input  logic              compressed_mode,
  input  ppu_pkg::qstat_t   q_stat,
  output logic              push,
  output ppu_pkg::op_t      push_op
);
  import ppu_pkg::*;

  logic             in_literal, in_literal_next;
  logic             repeat_pending, repeat_pending_next;
  logic [RUN_W-1:0] run_left, run_left_next;
  logic             lit, rep;
  logic [RUN_W-1:0] rl, rl_dec;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    // A restart clears the packet state before the byte is looked at.
    lit    = in_literal && !in_item.first_byte;
    rep    = repeat_pending && !in_item.first_byte;
    rl     = in_item.first_byte ? '0 : run_left;
    rl_dec = (rl != '0) ? rl - RUN_W'(1) : '0;

    in_literal_next     = lit;
    repeat_pending_next = rep;
    run_left_next       = rl;

    push_op.data_byte = in_item.in_byte;
    push_op.first     = in_item.first_byte;
    push_op.count     = '0;
    push_op.row_check = 1'b0;

    if (!compressed_mode) begin
      push_op.count     = RUN_W'(1);
      push_op.row_check = 1'b1;
    end else if (rep) begin
      push_op.count       = rl;
      push_op.row_check   = 1'b1;
      repeat_pending_next = 1'b0;
      in_literal_next     = 1'b0;
      run_left_next       = '0;
    end else if (lit) begin
      push_op.count     = RUN_W'(1);
      push_op.row_check = (rl_dec == '0);
      run_left_next     = rl_dec;
      in_literal_next   = (rl_dec != '0);
    end else if (in_item.in_byte < CTRL_REPEAT) begin
      in_literal_next = 1'b1;
      run_left_next   = in_item.in_byte + RUN_W'(1);
    end else begin
      repeat_pending_next = 1'b1;
      run_left_next       = RUN_W'(REPEAT_BASE - {1'b0, in_item.in_byte});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_literal     <= 1'b0;
      repeat_pending <= 1'b0;
      run_left       <= '0;
    end else if (push) begin
      in_literal     <= in_literal_next;
      repeat_pending <= repeat_pending_next;
      run_left       <= run_left_next;
    end
  end

endmodule

FILE: hw/rtl/ppu_queue.sv
// Short op queue between the front end and the back end.
module ppu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ppu_pkg::op_t    push_op,
  input  logic            pop,
  output ppu_pkg::op_t    pop_op,
  output ppu_pkg::qstat_t q_stat
);
  import ppu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign q_stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_op       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/ppu_back.sv
// Back end: walks picture position, writes row bytes in four-byte groups, drives results.
module ppu_back #(
  parameter int MAX_PLANES    = ppu_pkg::MAX_PLANES_DEFAULT,
  parameter int MAX_ROW_BYTES = ppu_pkg::MAX_ROW_BYTES_DEFAULT,
  parameter int MAX_LINES     = ppu_pkg::MAX_LINES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  ppu_pkg::cfg_t      cfg,
  input  ppu_pkg::qstat_t    q_stat,
  input  ppu_pkg::op_t       pop_op,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ppu_pkg::out_item_t out_item
);
  import ppu_pkg::*;

  localparam int PC_W = $clog2(MAX_PLANES + 1);
  localparam int RB_W = $clog2(MAX_ROW_BYTES + 1);
  localparam int LC_W = $clog2(MAX_LINES + 1);
  localparam int PL_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int LN_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int ST_W = PC_W + RB_W - 1;
  localparam int PR_W = LN_W + ST_W;
  localparam int GO_W = RB_W + PC_W + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BASE = 3'b010,
    S_RUN  = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [BYTE_W-1:0] cur_byte, cur_byte_next;
  logic [RUN_W-1:0]  left, left_next;
  logic              row_check, row_check_next;
  logic [RB_W-1:0]   rp, rp_next;
  logic [PL_W-1:0]   plane, plane_next;
  logic [LN_W-1:0]   line, line_next;
  logic              over, over_next;
  logic [ST_W-1:0]   stride;
  logic [ADDR_W-1:0] row_base;
  logic              out_valid_next;
  out_item_t         out_item_next;

  logic [PC_W-1:0]   planes_eff;
  logic [RB_W-1:0]   rows_raw, rows_eff;
  logic [LC_W-1:0]   lines_eff;
  logic [PR_W-1:0]   base_prod;

  logic [RB_W-1:0]   room, rp_n;
  logic [2:0]        avail, cnt;
  logic [RUN_W-1:0]  left_n;
  logic              writing, fin, row_end, plane_wrap, line_wrap, done, ovr, emit_run;
  logic [LANE_W-1:0] lanes;
  logic [DATA_W-1:0] data;
  logic [GO_W-1:0]   grp_off;
  logic [ADDR_W-1:0] addr;
  logic              out_free, load_out, finish;

  // Register values out of range are clamped; the row is kept even.
  always_comb begin
    if (cfg.plane_count == '0) begin
      planes_eff = PC_W'(1);
    end else if (int'(cfg.plane_count) > MAX_PLANES) begin
      planes_eff = PC_W'(MAX_PLANES);
    end else begin
      planes_eff = PC_W'(cfg.plane_count);
    end
    if (int'(cfg.row_bytes) < 2) begin
      rows_raw = RB_W'(2);
    end else if (int'(cfg.row_bytes) > MAX_ROW_BYTES) begin
      rows_raw = RB_W'(MAX_ROW_BYTES);
    end else begin
      rows_raw = RB_W'(cfg.row_bytes);
    end
    rows_eff = {rows_raw[RB_W-1:1], 1'b0};
    if (cfg.line_count == '0) begin
      lines_eff = LC_W'(1);
    end else if (int'(cfg.line_count) > MAX_LINES) begin
      lines_eff = LC_W'(MAX_LINES);
    end else begin
      lines_eff = LC_W'(cfg.line_count);
    end
  end

  assign base_prod = PR_W'(line) * PR_W'(stride);

  // One four-byte group per cycle while the output is free: the byte count stops at the group, row or run end.
  always_comb begin
    room  = rows_eff - rp;
    avail = 3'd4 - {1'b0, rp[1:0]};
    cnt   = avail;
    if (int'(room) < int'(cnt)) begin
      cnt = 3'(room);
    end
    if (int'(left) < int'(cnt)) begin
      cnt = 3'(left);
    end
    writing = (rp < rows_eff) && (left != '0);
    rp_n    = writing ? rp + RB_W'(cnt) : rp;
    left_n  = writing ? left - RUN_W'(cnt) : left;
    fin     = !writing || (left_n == '0) || (rp_n >= rows_eff);
    row_end = row_check && (rp_n >= rows_eff);

    plane_wrap = !(int'(plane) + 1 < int'(planes_eff));
    line_wrap  = !(int'(line) + 1 < int'(lines_eff));
    done       = fin && row_end && plane_wrap && line_wrap;
    ovr        = fin && (left_n != '0);
    emit_run   = writing || ovr || done;

    for (int k = 0; k < LANE_W; k++) begin
      lanes[LANE_W-1-k] = writing && (k >= int'(rp[1:0])) &&
                          (k < int'(rp[1:0]) + int'(cnt));
      data[BYTE_W*(LANE_W-1-k) +: BYTE_W] = lanes[LANE_W-1-k] ? cur_byte : '0;
    end

    grp_off = GO_W'(rp >> 2) * GO_W'({planes_eff, 1'b0});
    addr    = writing ? row_base + ADDR_W'(grp_off) : '0;
  end

  always_comb begin
    state_next     = state;
    cur_byte_next  = cur_byte;
    left_next      = left;
    row_check_next = row_check;
    rp_next        = rp;
    plane_next     = plane;
    line_next      = line;
    over_next      = over;
    out_item_next  = out_item;
    out_free       = !out_valid || out_ready;
    load_out       = 1'b0;
    finish         = 1'b0;
    pop            = 1'b0;

    case (state)
      S_IDLE: begin
        finish = 1'b1;
      end
      S_BASE: begin
        if (over) begin
          // Past the picture end every byte is dropped with one flagged beat.
          if (out_free) begin
            load_out                   = 1'b1;
            out_item_next              = '0;
            out_item_next.overrun      = 1'b1;
            out_item_next.last_of_run  = 1'b1;
            finish                     = 1'b1;
          end
        end else begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (out_free) begin
          rp_next   = rp_n;
          left_next = left_n;
          if (emit_run) begin
            load_out                   = 1'b1;
            out_item_next.out_word_addr = addr;
            out_item_next.out_data      = data;
            out_item_next.out_lanes     = lanes;
            out_item_next.picture_done  = done;
            out_item_next.overrun       = ovr;
            out_item_next.last_of_run   = fin;
          end
          if (fin) begin
            finish = 1'b1;
            if (row_end) begin
              rp_next = '0;
              if (!plane_wrap) begin
                plane_next = plane + PL_W'(1);
              end else begin
                plane_next = '0;
                if (!line_wrap) begin
                  line_next = line + LN_W'(1);
                end else begin
                  over_next = 1'b1;
                end
              end
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      state_next = S_IDLE;
      if (!q_stat.empty) begin
        pop            = 1'b1;
        cur_byte_next  = pop_op.data_byte;
        left_next      = pop_op.count;
        row_check_next = pop_op.row_check;
        state_next     = S_BASE;
        if (pop_op.first) begin
          rp_next    = '0;
          plane_next = '0;
          line_next  = '0;
          over_next  = 1'b0;
        end
      end
    end

    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    cur_byte <= cur_byte_next;
    out_item <= out_item_next;
    stride   <= ST_W'(planes_eff) * ST_W'(rows_eff >> 1);
    if (state == S_BASE) begin
      row_base <= ADDR_W'(base_prod + PR_W'(plane));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      left      <= '0;
      row_check <= 1'b0;
      rp        <= '0;
      plane     <= '0;
      line      <= '0;
      over      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      left      <= left_next;
      row_check <= row_check_next;
      rp        <= rp_next;
      plane     <= plane_next;
      line      <= line_next;
      over      <= over_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: tb/sv/tb_packbits_plane_unpacker_core.sv
// Self-checking testbench of the plane unpacker core, checked beat by beat against a predictor.
module tb_packbits_plane_unpacker_core;
  import ppu_pkg::*;

  localparam int IDLE_PCT      = 37;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 10;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_we;
  reg_idx_t              cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor copy of the registers and of the decoder position.
  cfg_t                  shadow_cfg;
  logic                  lit_open;
  logic                  rep_open;
  logic                  pic_closed;
  logic [RUN_W-1:0]      packet_left;
  logic [ROWS_REG_W-1:0] row_pos;
  logic [1:0]            plane_idx;
  logic [9:0]            line_idx;

  // Beats of the byte being predicted, and beats still owed by the block.
  out_item_t             step_beats[$];
  out_item_t             pending_beats[$];
  bit                    group_open;
  int                    group_addr;
  logic [DATA_W-1:0]     group_data;
  logic [LANE_W-1:0]     group_lanes;
  bit                    dropped;
  bit                    finished;

  bit steady       = 1'b0;
  bit hold_pending = 1'b0;
  int items_sent   = 0;
  int beat_errors  = 0;
  int quiet_cycles = 0;

  packbits_plane_unpacker_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int planes_used();
    int p;
    p = int'(shadow_cfg.plane_count);
    if (p < 1) p = 1;
    if (p > MAX_PLANES_DEFAULT) p = MAX_PLANES_DEFAULT;
    return p;
  endfunction

  function automatic int rows_used();
    int r;
    r = int'(shadow_cfg.row_bytes);
    if (r < 2) r = 2;
    if (r > MAX_ROW_BYTES_DEFAULT) r = MAX_ROW_BYTES_DEFAULT;
    return r - (r % 2);
  endfunction

  function automatic int lines_used();
    int l;
    l = int'(shadow_cfg.line_count);
    if (l < 1) l = 1;
    if (l > MAX_LINES_DEFAULT) l = MAX_LINES_DEFAULT;
    return l;
  endfunction

  task automatic close_group();
    out_item_t beat;
    if (group_open) begin
      beat = '0;
      beat.out_word_addr = ADDR_W'(group_addr);
      beat.out_data = group_data;
      beat.out_lanes = group_lanes;
      step_beats.push_back(beat);
    end
    group_open = 1'b0;
  endtask

  // Writes one decoded byte into the open four-byte group, or drops it past the row end.
  task automatic place_byte(input logic [BYTE_W-1:0] b);
    int addr;
    int lane;
    if (int'(row_pos) >= rows_used()) begin
      dropped = 1'b1;
    end else begin
      addr = int'(line_idx) * planes_used() * (rows_used() / 2)
           + (int'(row_pos) / 4) * 2 * planes_used() + int'(plane_idx);
      if (!group_open || addr != group_addr) begin
        close_group();
        group_open = 1'b1;
        group_addr = addr;
        group_data = '0;
        group_lanes = '0;
      end
      lane = 3 - (int'(row_pos) % 4);
      group_data[lane*8 +: 8] = b;
      group_lanes[lane] = 1'b1;
      row_pos = row_pos + ROWS_REG_W'(1);
    end
  endtask

  task automatic next_row();
    row_pos = '0;
    if (int'(plane_idx) + 1 < planes_used()) begin
      plane_idx = plane_idx + 2'd1;
    end else begin
      plane_idx = '0;
      if (int'(line_idx) + 1 < lines_used()) begin
        line_idx = line_idx + 10'd1;
      end else begin
        pic_closed = 1'b1;
        finished = 1'b1;
      end
    end
  endtask

  // Works out the beats that one accepted byte causes and queues them.
  task automatic unpack_byte(input in_item_t it);
    int        n;
    out_item_t beat;
    step_beats.delete();
    group_open = 1'b0;
    dropped = 1'b0;
    finished = 1'b0;
    if (it.first_byte) begin
      lit_open = 1'b0;
      rep_open = 1'b0;
      packet_left = '0;
      row_pos = '0;
      plane_idx = '0;
      line_idx = '0;
      pic_closed = 1'b0;
    end
    if (pic_closed) begin
      dropped = 1'b1;
    end else if (!shadow_cfg.compressed_mode) begin
      place_byte(it.in_byte);
      if (int'(row_pos) >= rows_used()) next_row();
    end else begin
      if (rep_open) begin
        n = int'(packet_left);
        repeat (n) place_byte(it.in_byte);
        packet_left = '0;
        rep_open = 1'b0;
        lit_open = 1'b0;
      end else if (lit_open) begin
        place_byte(it.in_byte);
        if (packet_left > 0) packet_left = packet_left - RUN_W'(1);
        if (packet_left == 0) lit_open = 1'b0;
      end else if (it.in_byte < CTRL_REPEAT) begin
        lit_open = 1'b1;
        packet_left = it.in_byte + RUN_W'(1);
      end else begin
        rep_open = 1'b1;
        packet_left = RUN_W'(REPEAT_BASE - {1'b0, it.in_byte});
      end
      if (!lit_open && !rep_open && int'(row_pos) >= rows_used()) next_row();
    end
    close_group();
    // A flag with nothing written still needs an empty beat to carry it.
    if (step_beats.size() == 0 && (dropped || finished)) begin
      beat = '0;
      step_beats.push_back(beat);
    end
    if (step_beats.size() != 0) begin
      beat = step_beats.pop_back();
      beat.picture_done = finished;
      beat.overrun = dropped;
      beat.last_of_run = 1'b1;
      step_beats.push_back(beat);
    end
    foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first);
    in_item_t it;
    it.in_byte = b;
    it.first_byte = first;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    unpack_byte(it);
    items_sent++;
  endtask

  // Stops offering, waits for every owed beat, then lets trailing control bytes settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    cfg_we <= 1'b1;
    cfg_addr <= REG_MODE;
    cfg_wdata <= CFG_DATA_W'(c.compressed_mode);
    @(posedge clk);
    cfg_addr <= REG_PLANES;
    cfg_wdata <= CFG_DATA_W'(c.plane_count);
    @(posedge clk);
    cfg_addr <= REG_ROW_BYTES;
    cfg_wdata <= CFG_DATA_W'(c.row_bytes);
    @(posedge clk);
    cfg_addr <= REG_LINES;
    cfg_wdata <= CFG_DATA_W'(c.line_count);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cfg = c;
  endtask

  // Codes one plane row as packets; a few packets run past the row end on purpose.
  task automatic send_plane_row(input int row_len, input bit first, input int rep_pct);
    int left;
    int len;
    int top;
    bit lead;
    left = row_len;
    lead = first;
    while (left > 0) begin
      if (left >= 2 && $urandom_range(99) < rep_pct) begin
        top = (left < 129) ? left : 129;
        len = $urandom_range(2, top);
        if ($urandom_range(99) < 8) len = (left + 3 < 129) ? left + 3 : 129;
        send_byte(BYTE_W'(int'(REPEAT_BASE) - len), lead);
        send_byte(BYTE_W'($urandom), 1'b0);
      end else begin
        top = (left < 8) ? left : 8;
        len = $urandom_range(1, top);
        if ($urandom_range(99) < 8) len = left + $urandom_range(1, 3);
        if (len > 128) len = 128;
        send_byte(BYTE_W'(len - 1), lead);
        repeat (len) send_byte(BYTE_W'($urandom), 1'b0);
      end
      lead = 1'b0;
      left -= len;
    end
  endtask

  task automatic send_picture(input int rep_pct);
    for (int r = 0; r < planes_used() * lines_used(); r++) begin
      send_plane_row(rows_used(), r == 0, rep_pct);
    end
  endtask

  // Literal and repeat packets under the reset register values.
  task automatic test_packet_kinds();
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h81, 1'b0);
    // The longest repeat run is cut at the end of the 40-byte row.
    send_byte(8'h80, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    drain_results();
  endtask

  task automatic test_picture_end();
    apply_config(cfg_t'{1'b0, 3'd1, 9'd2, 11'd1});
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h9A, 1'b1);
    send_byte(8'hBC, 1'b0);
    drain_results();
    // The third literal is dropped and ends the picture without writing anything.
    apply_config(cfg_t'{1'b1, 3'd1, 9'd2, 11'd1});
    send_byte(8'h02, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    drain_results();
  endtask

  task automatic test_register_clamps();
    apply_config(cfg_t'{1'b1, 3'd0, 9'd1, 11'd0});
    send_byte(8'hFE, 1'b1);
    send_byte(8'h44, 1'b0);
    drain_results();
    apply_config(cfg_t'{1'b0, 3'd7, 9'd511, 11'd2047});
    send_byte(8'h01, 1'b1);
    send_byte(8'hEE, 1'b0);
    drain_results();
    apply_config(cfg_t'{1'b0, 3'd5, 9'd3, 11'd1025});
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b0);
    drain_results();
  endtask

  task automatic test_random_pictures();
    int start;
    start = items_sent;
    // An odd row width is rounded down to an even one.
    apply_config(cfg_t'{1'b1, 3'd1, 9'd255, 11'd1});
    send_picture(90);
    send_byte(BYTE_W'($urandom), 1'b0);
    drain_results();
    while (items_sent - start < 20) begin
      apply_config(cfg_t'{1'b1, 3'($urandom_range(1, 4)), 9'(2 * $urandom_range(1, 8)),
                          11'($urandom_range(1, 3))});
      send_picture(40);
      if ($urandom_range(1)) send_byte(BYTE_W'($urandom), 1'b0);
      drain_results();
    end
  endtask

  task automatic test_mid_picture_change();
    apply_config(cfg_t'{1'b1, 3'd4, 9'd12, 11'd3});
    for (int r = 0; r < 3; r++) send_plane_row(12, r == 0, 30);
    // Stop ten bytes into the fourth plane row, past the bounds set next.
    send_byte(8'h09, 1'b0);
    repeat (10) send_byte(BYTE_W'($urandom), 1'b0);
    drain_results();
    apply_config(cfg_t'{1'b1, 3'd2, 9'd6, 11'd2});
    for (int r = 0; r < 3; r++) send_plane_row(6, 1'b0, 30);
    send_byte(BYTE_W'($urandom), 1'b0);
    drain_results();
  endtask

  task automatic test_receiver_hold();
    apply_config(cfg_t'{1'b1, 3'd2, 9'd16, 11'd2});
    hold_pending = 1'b1;
    send_picture(60);
    drain_results();
    send_picture(60);
    drain_results();
  endtask

  task automatic test_copy_stream();
    apply_config(cfg_t'{1'b0, 3'($urandom_range(1, 4)), 9'd4, 11'd2});
    steady = 1'b1;
    for (int i = 0; i < 40; i++) send_byte(BYTE_W'($urandom), i % 20 == 0);
    steady = 1'b0;
    drain_results();
  endtask

  task automatic test_noise();
    apply_config(cfg_t'{1'b1, 3'd3, 9'd6, 11'd2});
    for (int i = 0; i < 30; i++) begin
      send_byte(BYTE_W'($urandom), i == 0 || $urandom_range(7) == 0);
    end
    drain_results();
  endtask

  // Receiver: random stalls, none while steady, and one long hold when asked.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 1'b0;
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_beats
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        beat_errors++;
        if (beat_errors <= MAX_REPORTS) begin
          $display("unexpected beat: addr %h data %h lanes %h done %b ovr %b last %b",
                   out_item.out_word_addr, out_item.out_data, out_item.out_lanes,
                   out_item.picture_done, out_item.overrun, out_item.last_of_run);
        end
      end else begin
        want = pending_beats.pop_front();
        if (out_item.out_word_addr !== want.out_word_addr ||
            out_item.out_data !== want.out_data ||
            out_item.out_lanes !== want.out_lanes ||
            out_item.picture_done !== want.picture_done ||
            out_item.overrun !== want.overrun ||
            out_item.last_of_run !== want.last_of_run) begin
          beat_errors++;
          if (beat_errors <= MAX_REPORTS) begin
            $display("beat mismatch: expected addr %h data %h lanes %h done %b ovr %b last %b",
                     want.out_word_addr, want.out_data, want.out_lanes,
                     want.picture_done, want.overrun, want.last_of_run);
            $display("               actual   addr %h data %h lanes %h done %b ovr %b last %b",
                     out_item.out_word_addr, out_item.out_data, out_item.out_lanes,
                     out_item.picture_done, out_item.overrun, out_item.last_of_run);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_MODE;
    cfg_wdata <= '0;
    shadow_cfg = CFG_RESET;
    lit_open = 1'b0;
    rep_open = 1'b0;
    pic_closed = 1'b0;
    packet_left = '0;
    row_pos = '0;
    plane_idx = '0;
    line_idx = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_packet_kinds();
    test_picture_end();
    test_register_clamps();
    test_random_pictures();
    test_mid_picture_change();
    test_receiver_hold();
    test_copy_stream();
    test_noise();
    if (beat_errors == 0 && pending_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ppu_pkg.sv
hw/rtl/ppu_front.sv
hw/rtl/ppu_queue.sv
hw/rtl/ppu_back.sv
hw/rtl/packbits_plane_unpacker_core.sv
tb/sv/tb_packbits_plane_unpacker_core.sv
